// File: src/lcdseq_pkg.sv
`default_nettype none

package lcdseq_pkg;

  // Request codes
  typedef enum logic [2:0] {
    ACT_INIT  = 3'd0,
    ACT_CLEAR = 3'd1,
    ACT_CTRL  = 3'd2,
    ACT_MOVE  = 3'd3,
    ACT_CHAR  = 3'd4,
    ACT_GLYPH = 3'd5
  } action_e;

  // Settle time after the strobe that ends an op
  typedef enum logic [1:0] {
    WAIT_NONE  = 2'd0,
    WAIT_SHORT = 2'd1,
    WAIT_LONG  = 2'd2,
    WAIT_WAKE  = 2'd3
  } wait_e;

  localparam int unsigned WaitW = 13;

  localparam logic [WaitW-1:0] WaitShortUs = 13'd60;
  localparam logic [WaitW-1:0] WaitLongUs  = 13'd3000;
  localparam logic [WaitW-1:0] WaitWakeUs  = 13'd5000;

  // LCD command bytes
  localparam logic [7:0] CmdClear    = 8'h01;
  localparam logic [7:0] CmdEntry    = 8'h06;
  localparam logic [7:0] CmdCtrl     = 8'h08;
  localparam logic [7:0] CmdDispOn   = 8'h0C;
  localparam logic [7:0] CmdFuncSet  = 8'h20;
  localparam logic [7:0] CmdCgram    = 8'h40;
  localparam logic [7:0] CmdDdram    = 8'h80;
  localparam logic [7:0] FsTwoLines  = 8'h08;
  localparam logic [7:0] FsTallFont  = 8'h04;
  localparam logic [3:0] NibWake     = 4'h3;
  localparam logic [3:0] NibFourBit  = 4'h2;

  // Config register indexes
  localparam logic RegTwoLines = 1'b0;
  localparam logic RegTallFont = 1'b1;

  // One queued op: a full byte (two nibbles) or a single nibble in data[3:0]
  typedef struct packed {
    logic       single;
    logic       rs;
    logic [7:0] data;
    wait_e      wait_sel;
    logic       last;
  } op_t;

  function automatic logic [7:0] line_base(input logic [1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      default: base = 8'h54;
    endcase
    return base;
  endfunction

  function automatic logic [WaitW-1:0] wait_us(input wait_e sel);
    logic [WaitW-1:0] us;
    case (sel)
      WAIT_SHORT: us = WaitShortUs;
      WAIT_LONG:  us = WaitLongUs;
      WAIT_WAKE:  us = WaitWakeUs;
      default:    us = '0;
    endcase
    return us;
  endfunction

endpackage

`default_nettype wire

// File: src/char_lcd_nibble_command_sequencer_top.sv
// A request's first nibble is strobed after the request, queue and result registers.
// Throughput: one nibble per cycle while the queue holds ops; a byte is two nibbles.
// The request decoder holds one request and queues one op per cycle while the
// queue has room; busy is high while a request is held, until its last op is queued.
// Results cannot be stalled. Reset clears the queue and sets two_lines=1, tall_font=0.
`default_nettype none

module char_lcd_nibble_command_sequencer_top import lcdseq_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] action_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic [5:0] column_i,
  input  wire logic [1:0] row_sel_i,
  input  wire logic [2:0] glyph_slot_i,
  input  wire logic [3:0] glyph_line_i,
  input  wire logic [7:0] glyph_bits_i,
  input  wire logic       display_on_i,
  input  wire logic       cursor_on_i,
  input  wire logic       cursor_blink_i,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic       cfg_data_i,
  output logic            out_strobe_o,
  output logic            reg_select_o,
  output logic [3:0]      nibble_o,
  output logic [12:0]     wait_us_o,
  output logic            last_o
);

  logic two_lines_q, tall_font_q;
  logic push, q_ready, q_valid, pop;
  op_t  push_op, head_op;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_lines_q <= 1'b1;
      tall_font_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegTwoLines) begin
        two_lines_q <= cfg_data_i;
      end
      if (cfg_idx_i == RegTallFont) begin
        tall_font_q <= cfg_data_i;
      end
    end
  end

  lcdseq_front u_front (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .action_i,
    .char_code_i,
    .column_i,
    .row_sel_i,
    .glyph_slot_i,
    .glyph_line_i,
    .glyph_bits_i,
    .display_on_i,
    .cursor_on_i,
    .cursor_blink_i,
    .two_lines_i (two_lines_q),
    .tall_font_i (tall_font_q),
    .push_o      (push),
    .op_o        (push_op),
    .ready_i     (q_ready)
  );

  lcdseq_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i (push_op),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (head_op)
  );

  lcdseq_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i (q_valid),
    .op_i    (head_op),
    .pop_o   (pop),
    .out_strobe_o,
    .reg_select_o,
    .nibble_o,
    .wait_us_o,
    .last_o
  );

endmodule

`default_nettype wire

// File: src/lcdseq_front.sv
`default_nettype none

module lcdseq_front import lcdseq_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] action_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic [5:0] column_i,
  input  wire logic [1:0] row_sel_i,
  input  wire logic [2:0] glyph_slot_i,
  input  wire logic [3:0] glyph_line_i,
  input  wire logic [7:0] glyph_bits_i,
  input  wire logic       display_on_i,
  input  wire logic       cursor_on_i,
  input  wire logic       cursor_blink_i,
  input  wire logic       two_lines_i,
  input  wire logic       tall_font_i,
  output logic            push_o,
  output op_t             op_o,
  input  wire logic       ready_i
);

  logic       valid_q, valid_d;
  logic [3:0] step_q, step_d;
  logic [2:0] act_q;
  logic [7:0] char_q;
  logic [5:0] col_q;
  logic [1:0] row_q;
  logic [2:0] slot_q;
  logic [3:0] gline_q;
  logic [7:0] gbits_q;
  logic [2:0] ctrl_q;

  logic       accept;
  logic       known;
  logic       glyph_final;
  logic [5:0] cg_addr;
  logic [7:0] fs_byte;

  assign accept = start && !busy;
  assign known  = (action_i <= ACT_GLYPH);

  // Glyph row position against the font height
  assign glyph_final = tall_font_i ? (gline_q == 4'd9) : (gline_q == 4'd7);
  // slot * rows, low six bits: slot*8 plus slot*2 for the tall font
  assign cg_addr = {slot_q, 3'b000} + (tall_font_i ? {2'b00, slot_q, 1'b0} : 6'd0);
  assign fs_byte = CmdFuncSet | (two_lines_i ? FsTwoLines : 8'h00)
                 | (tall_font_i ? FsTallFont : 8'h00);

  // Op for the current step of the held request
  always_comb begin
    op_o = '{single: 1'b0, rs: 1'b0, data: 8'h00, wait_sel: WAIT_SHORT, last: 1'b1};
    unique case (action_e'(act_q))
      ACT_INIT: begin
        op_o.last = 1'b0;
        case (step_q) inside
          4'd0, 4'd1, 4'd2: begin
            op_o.single   = 1'b1;
            op_o.data     = {4'h0, NibWake};
            op_o.wait_sel = WAIT_WAKE;
          end
          4'd3: begin
            op_o.single = 1'b1;
            op_o.data   = {4'h0, NibFourBit};
          end
          4'd4: op_o.data = fs_byte;
          4'd5: op_o.data = CmdCtrl;
          4'd6: begin
            op_o.data     = CmdClear;
            op_o.wait_sel = WAIT_LONG;
          end
          4'd7: op_o.data = CmdEntry;
          default: begin
            op_o.data = CmdDispOn;
            op_o.last = 1'b1;
          end
        endcase
      end
      ACT_CLEAR: begin
        op_o.data     = CmdClear;
        op_o.wait_sel = WAIT_LONG;
      end
      ACT_CTRL:  op_o.data = CmdCtrl | {5'b00000, ctrl_q};
      ACT_MOVE:  op_o.data = CmdDdram + line_base(row_q) + {2'b00, col_q};
      ACT_CHAR: begin
        op_o.rs   = 1'b1;
        op_o.data = char_q;
      end
      ACT_GLYPH: begin
        case (step_q)
          4'd0: begin
            op_o.data = CmdCgram | {2'b00, cg_addr};
            op_o.last = 1'b0;
          end
          4'd1: begin
            op_o.rs   = 1'b1;
            op_o.data = gbits_q;
            op_o.last = !glyph_final;
          end
          default: op_o.data = CmdDdram;
        endcase
      end
      default: ;
    endcase
  end

  assign push_o = valid_q && ready_i;
  // Free to take a new request in the cycle the last op goes into the queue
  assign busy   = valid_q && !(push_o && op_o.last);

  always_comb begin
    valid_d = valid_q;
    step_d  = step_q;
    if (accept) begin
      valid_d = known;
      step_d  = ((action_i == ACT_GLYPH) && (glyph_line_i != 4'd0)) ? 4'd1 : 4'd0;
    end else if (push_o) begin
      if (op_o.last) begin
        valid_d = 1'b0;
      end else begin
        step_d = step_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
    end else begin
      valid_q <= valid_d;
      step_q  <= step_d;
    end
  end

  // Request fields, captured on transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_i;
      char_q  <= char_code_i;
      col_q   <= column_i;
      row_q   <= row_sel_i;
      slot_q  <= glyph_slot_i;
      gline_q <= glyph_line_i;
      gbits_q <= glyph_bits_i;
      ctrl_q  <= {display_on_i, cursor_on_i, cursor_blink_i};
    end
  end

endmodule

`default_nettype wire

// File: src/lcdseq_fifo.sv
`default_nettype none

module lcdseq_fifo import lcdseq_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  wdata_i,
  output logic      ready_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output op_t       rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  op_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntFull);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Pointers wrap at the depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/lcdseq_back.sv
`default_nettype none

module lcdseq_back import lcdseq_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire op_t       op_i,
  output logic           pop_o,
  output logic           out_strobe_o,
  output logic           reg_select_o,
  output logic [3:0]     nibble_o,
  output logic [WaitW-1:0] wait_us_o,
  output logic           last_o
);

  logic             phase_q, phase_d;
  logic             strobe_q;
  logic             rs_q, rs_d;
  logic [3:0]       nib_q, nib_d;
  logic [WaitW-1:0] wait_q, wait_d;
  logic             last_q, last_d;

  // A byte goes out high nibble first, the low nibble carries the settle time
  always_comb begin
    phase_d = phase_q;
    pop_o   = 1'b0;
    rs_d    = op_i.rs;
    nib_d   = op_i.data[3:0];
    wait_d  = wait_us(op_i.wait_sel);
    last_d  = op_i.last;
    if (valid_i) begin
      if (op_i.single || phase_q) begin
        pop_o   = 1'b1;
        phase_d = 1'b0;
      end else begin
        nib_d   = op_i.data[7:4];
        wait_d  = wait_us(WAIT_NONE);
        last_d  = 1'b0;
        phase_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      strobe_q <= valid_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      rs_q   <= rs_d;
      nib_q  <= nib_d;
      wait_q <= wait_d;
      last_q <= last_d;
    end
  end

  assign out_strobe_o = strobe_q;
  assign reg_select_o = rs_q;
  assign nibble_o     = nib_q;
  assign wait_us_o    = wait_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire
